// ----- design/dcd_pkg.sv -----
// shared constants, codes and control structs for the task dispatcher
// used by dcd_ctrl, dcd_dpath and the top level
package dcd_pkg;

    localparam int MAX_TASKS = 32;
    localparam int NT        = (MAX_TASKS > 32) ? 32 : MAX_TASKS;
    localparam int IDX_W     = (NT > 1) ? $clog2(NT) : 1;
    localparam int ID_W      = 5;
    localparam int CNT_W     = 6;
    localparam logic [ID_W:0] NT_LIM = (ID_W + 1)'(NT);

    // actions
    localparam logic [2:0] A_ADD_TASK = 3'd0;
    localparam logic [2:0] A_REM_TASK = 3'd1;
    localparam logic [2:0] A_ADD_DEP  = 3'd2;
    localparam logic [2:0] A_REM_DEP  = 3'd3;
    localparam logic [2:0] A_START    = 3'd4;
    localparam logic [2:0] A_CANCEL   = 3'd5;
    localparam logic [2:0] A_FINISH   = 3'd6;

    // phases
    localparam logic [2:0] PH_READY      = 3'd0;
    localparam logic [2:0] PH_STARTED    = 3'd1;
    localparam logic [2:0] PH_CANCELLING = 3'd2;
    localparam logic [2:0] PH_CANCELLED  = 3'd3;
    localparam logic [2:0] PH_DONE       = 3'd4;

    // result kinds
    localparam logic [2:0] K_STATUS    = 3'd0;
    localparam logic [2:0] K_DISPATCH  = 3'd1;
    localparam logic [2:0] K_CANCEL    = 3'd2;
    localparam logic [2:0] K_DONE      = 3'd3;
    localparam logic [2:0] K_CANCELLED = 3'd4;

    // status codes
    localparam logic [2:0] S_OK       = 3'd0;
    localparam logic [2:0] S_PERM     = 3'd1;
    localparam logic [2:0] S_INVALID  = 3'd2;
    localparam logic [2:0] S_EMPTY    = 3'd3;
    localparam logic [2:0] S_MULTI    = 3'd4;
    localparam logic [2:0] S_CIRCULAR = 3'd5;
    localparam logic [2:0] S_ISOLATED = 3'd6;
    localparam logic [2:0] S_CONFLICT = 3'd7;

    typedef struct packed {
        logic       capture;
        logic       add_task;
        logic       add_dep;
        logic       rem_dep;
        logic       detach;
        logic       dec_succ;
        logic       unf_dec;
        logic       pend_fin;
        logic       pend_cancel;
        logic       pend_start;
        logic       pend_pop;
        logic       start_init;
        logic       visit_step;
        logic       prune_init;
        logic       prune_step;
        logic       set_phase;
        logic [2:0] phase_val;
        logic       push;
        logic [2:0] kind;
        logic [2:0] status;
        logic       task_root;
        logic       task_pend;
        logic       last;
    } dcd_cmd_t;

    typedef struct packed {
        logic [2:0] act;
        logic [2:0] phase;
        logic       out_free;
        logic       t_in_range;
        logic       t_valid;
        logic       p_valid;
        logic       edge_hit;
        logic       unf_zero;
        logic       unf_one;
        logic       empty;
        logic       root_none;
        logic       root_multi;
        logic       start_cand_empty;
        logic       fin_cand_empty;
        logic       visit_changed;
        logic       remain_changed;
        logic       remain_nz;
        logic       visit_ne;
        logic       pend_nz;
        logic       pend_one;
    } dcd_stat_t;

endpackage

// ----- design/dcd_ctrl.sv -----
// controller state machine: sequences checks, graph walk and result beats
// depends on dcd_pkg
module dcd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  dcd_pkg::dcd_stat_t st,
    output dcd_pkg::dcd_cmd_t  cmd
);
    import dcd_pkg::*;

    localparam logic [2:0] C_IDLE  = 3'd0;
    localparam logic [2:0] C_EXEC  = 3'd1;
    localparam logic [2:0] C_VISIT = 3'd2;
    localparam logic [2:0] C_PRUNE = 3'd3;
    localparam logic [2:0] C_JUDGE = 3'd4;
    localparam logic [2:0] C_EMIT  = 3'd5;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == C_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = C_EXEC;
                end
            end
            C_EXEC:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = K_STATUS;
                    cmd.status = S_OK;
                    state_next = C_IDLE;
                    case (st.act) inside
                        A_ADD_TASK:
                        begin
                            if (st.phase != PH_READY)   cmd.status = S_PERM;
                            else if (!st.t_in_range)    cmd.status = S_INVALID;
                            else if (st.t_valid)        cmd.status = S_CONFLICT;
                            else                        cmd.add_task = 1'b1;
                        end
                        A_REM_TASK:
                        begin
                            if (!st.t_valid)                cmd.status = S_INVALID;
                            else if (st.phase != PH_READY)  cmd.status = S_PERM;
                            else
                            begin
                                cmd.detach   = 1'b1;
                                cmd.dec_succ = 1'b1;
                                cmd.unf_dec  = 1'b1;
                            end
                        end
                        A_ADD_DEP, A_REM_DEP:
                        begin
                            if (!st.t_valid || !st.p_valid)  cmd.status = S_INVALID;
                            else if (st.phase != PH_READY)   cmd.status = S_PERM;
                            else if (st.act == A_ADD_DEP)
                            begin
                                if (st.edge_hit) cmd.status  = S_CONFLICT;
                                else             cmd.add_dep = 1'b1;
                            end
                            else
                            begin
                                if (!st.edge_hit) cmd.status  = S_CONFLICT;
                                else              cmd.rem_dep = 1'b1;
                            end
                        end
                        A_START:
                        begin
                            if (st.phase != PH_READY)  cmd.status = S_PERM;
                            else if (st.empty)         cmd.status = S_EMPTY;
                            else if (st.root_multi)    cmd.status = S_MULTI;
                            else if (st.root_none)     cmd.status = S_CIRCULAR;
                            else
                            begin
                                cmd.push       = 1'b0;
                                cmd.start_init = 1'b1;
                                state_next     = C_VISIT;
                            end
                        end
                        A_CANCEL:
                        begin
                            if (st.phase != PH_READY && st.phase != PH_STARTED)
                                cmd.status = S_PERM;
                            else if (st.phase == PH_READY && st.unf_zero)
                            begin
                                cmd.set_phase = 1'b1;
                                cmd.phase_val = PH_CANCELLED;
                            end
                            else
                            begin
                                cmd.set_phase   = 1'b1;
                                cmd.phase_val   = PH_CANCELLING;
                                cmd.pend_cancel = 1'b1;
                                cmd.last        = st.empty;
                                if (!st.empty)
                                    state_next = C_EMIT;
                            end
                        end
                        A_FINISH:
                        begin
                            if (st.phase != PH_STARTED && st.phase != PH_CANCELLING)
                                cmd.status = S_PERM;
                            else if (!st.t_valid)
                                cmd.status = S_INVALID;
                            else
                            begin
                                cmd.detach  = 1'b1;
                                cmd.unf_dec = 1'b1;
                                if (st.unf_one)
                                begin
                                    // last outstanding task closes the run
                                    cmd.set_phase = 1'b1;
                                    if (st.phase == PH_CANCELLING)
                                    begin
                                        cmd.phase_val = PH_CANCELLED;
                                        cmd.kind      = K_CANCELLED;
                                    end
                                    else
                                    begin
                                        cmd.phase_val = PH_DONE;
                                        cmd.kind      = K_DONE;
                                        cmd.task_root = 1'b1;
                                    end
                                end
                                else if (st.phase == PH_STARTED)
                                begin
                                    cmd.dec_succ = 1'b1;
                                    cmd.pend_fin = 1'b1;
                                    cmd.last     = st.fin_cand_empty;
                                    if (!st.fin_cand_empty)
                                        state_next = C_EMIT;
                                end
                            end
                        end
                        default:
                            cmd.status = S_PERM;
                    endcase
                end
            end
            C_VISIT:
            begin
                if (st.visit_changed)
                    cmd.visit_step = 1'b1;
                else
                begin
                    cmd.prune_init = 1'b1;
                    state_next     = C_PRUNE;
                end
            end
            C_PRUNE:
            begin
                if (st.remain_changed)
                    cmd.prune_step = 1'b1;
                else
                    state_next = C_JUDGE;
            end
            C_JUDGE:
            begin
                if (st.out_free)
                begin
                    cmd.push   = 1'b1;
                    cmd.last   = 1'b1;
                    cmd.kind   = K_STATUS;
                    state_next = C_IDLE;
                    if (st.remain_nz)
                        cmd.status = S_CIRCULAR;
                    else if (st.visit_ne)
                        cmd.status = S_ISOLATED;
                    else
                    begin
                        cmd.status     = S_OK;
                        cmd.set_phase  = 1'b1;
                        cmd.phase_val  = PH_STARTED;
                        cmd.pend_start = 1'b1;
                        cmd.last       = st.start_cand_empty;
                        if (!st.start_cand_empty)
                            state_next = C_EMIT;
                    end
                end
            end
            C_EMIT:
            begin
                if (st.out_free)
                begin
                    cmd.push      = 1'b1;
                    cmd.kind      = (st.phase == PH_CANCELLING) ? K_CANCEL : K_DISPATCH;
                    cmd.status    = S_OK;
                    cmd.task_pend = 1'b1;
                    cmd.pend_pop  = 1'b1;
                    cmd.last      = st.pend_one;
                    if (st.pend_one)
                        state_next = C_IDLE;
                end
            end
            default:
                state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= C_IDLE;
        else
            state_reg <= state_next;
    end

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> st.out_free)
        else $error("result beat pushed into a full output register");

    a_emit_pend: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == C_EMIT |-> st.pend_nz)
        else $error("emit state with nothing pending");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> state_reg == C_EXEC)
        else $error("accepted beat not followed by execute");

endmodule

// ----- design/dcd_dpath.sv -----
// datapath: task table, counts, graph walk masks and output register
// depends on dcd_pkg
module dcd_dpath (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [2:0]              action,
    input  logic [dcd_pkg::ID_W-1:0] task_id,
    input  logic [dcd_pkg::ID_W-1:0] prereq_id,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [2:0]              kind,
    output logic [dcd_pkg::ID_W-1:0] result_task,
    output logic [2:0]              status,
    output logic                    last,
    input  dcd_pkg::dcd_cmd_t       cmd,
    output dcd_pkg::dcd_stat_t      st
);
    import dcd_pkg::*;

    logic [2:0]       act_reg;
    logic [ID_W-1:0]  t_reg, p_reg;
    logic [2:0]       phase_reg, phase_next;
    logic [NT-1:0]    present_reg, present_next;
    logic [NT-1:0]    rows_reg [NT];
    logic [NT-1:0]    rows_next [NT];
    logic [CNT_W-1:0] cnt_reg [NT];
    logic [CNT_W-1:0] cnt_next [NT];
    logic [CNT_W-1:0] unf_reg, unf_next;
    logic [IDX_W-1:0] root_reg, root_next;
    logic [NT-1:0]    visit_reg, visit_next;
    logic [NT-1:0]    remain_reg, remain_next;
    logic [NT-1:0]    pend_reg, pend_next;

    logic             out_valid_reg;
    logic [2:0]       kind_reg, status_reg;
    logic [ID_W-1:0]  task_reg;
    logic             last_reg;

    logic [IDX_W-1:0] t_idx, p_idx, rd_idx, root_idx, low_idx;
    logic [NT-1:0]    rd_row, t_bit, root_vec, cnt_zero, cnt_one, fin_vec;
    logic [NT-1:0]    visit_walk, remain_walk, pend_low;
    logic             p_in_range;

    assign t_idx  = t_reg[IDX_W-1:0];
    assign p_idx  = p_reg[IDX_W-1:0];
    assign rd_idx = (act_reg == A_ADD_DEP || act_reg == A_REM_DEP) ? p_idx : t_idx;
    assign rd_row = rows_reg[rd_idx];
    assign t_bit  = NT'(1) << t_idx;
    assign p_in_range = {1'b0, p_reg} < NT_LIM;
    assign pend_low   = pend_reg & (~pend_reg + NT'(1));

    always_comb
    begin
        root_idx = '0;
        low_idx  = '0;
        for (int i = 0; i < NT; i++)
        begin
            root_vec[i]    = present_reg[i] && (rows_reg[i] == '0);
            cnt_zero[i]    = (cnt_reg[i] == '0);
            cnt_one[i]     = (cnt_reg[i] == CNT_W'(1));
            fin_vec[i]     = rd_row[i] && cnt_one[i] && present_reg[i];
            visit_walk[i]  = visit_reg[i] | (present_reg[i] & (|(rows_reg[i] & visit_reg)));
            remain_walk[i] = remain_reg[i] & (|(rows_reg[i] & remain_reg));
            if (root_vec[i])
                root_idx = root_idx | IDX_W'(i);
            if (pend_low[i])
                low_idx = low_idx | IDX_W'(i);
        end
    end

    always_comb
    begin
        st.act              = act_reg;
        st.phase            = phase_reg;
        st.out_free         = !out_valid_reg || out_ready;
        st.t_in_range       = {1'b0, t_reg} < NT_LIM;
        st.t_valid          = st.t_in_range && present_reg[t_idx];
        st.p_valid          = p_in_range && present_reg[p_idx];
        st.edge_hit         = rd_row[t_idx];
        st.unf_zero         = (unf_reg == '0);
        st.unf_one          = (unf_reg == CNT_W'(1));
        st.empty            = (present_reg == '0);
        st.root_none        = (root_vec == '0);
        st.root_multi       = ((root_vec & (root_vec - NT'(1))) != '0);
        st.start_cand_empty = ((present_reg & cnt_zero) == '0);
        st.fin_cand_empty   = (fin_vec == '0);
        st.visit_changed    = (visit_walk != visit_reg);
        st.remain_changed   = (remain_walk != remain_reg);
        st.remain_nz        = (remain_reg != '0);
        st.visit_ne         = (visit_reg != present_reg);
        st.pend_nz          = (pend_reg != '0);
        st.pend_one         = ((pend_reg & (pend_reg - NT'(1))) == '0);
    end

    always_comb
    begin
        phase_next   = cmd.set_phase ? cmd.phase_val : phase_reg;
        present_next = present_reg;
        unf_next     = unf_reg;
        root_next    = root_reg;
        visit_next   = visit_reg;
        remain_next  = remain_reg;
        pend_next    = pend_reg;

        if (cmd.add_task)
        begin
            present_next = present_reg | t_bit;
            unf_next     = unf_reg + CNT_W'(1);
        end
        if (cmd.detach)
            present_next = present_reg & ~t_bit;
        if (cmd.unf_dec)
            unf_next = unf_reg - CNT_W'(1);

        if (cmd.start_init)
        begin
            root_next  = root_idx;
            visit_next = root_vec;
        end
        if (cmd.visit_step)
            visit_next = visit_walk;
        if (cmd.prune_init)
            remain_next = visit_reg;
        if (cmd.prune_step)
            remain_next = remain_walk;

        if (cmd.pend_fin)
            pend_next = fin_vec;
        else if (cmd.pend_cancel)
            pend_next = present_reg;
        else if (cmd.pend_start)
            pend_next = present_reg & cnt_zero;
        else if (cmd.pend_pop)
            pend_next = pend_reg & ~pend_low;

        for (int i = 0; i < NT; i++)
        begin
            rows_next[i] = rows_reg[i];
            cnt_next[i]  = cnt_reg[i];
            if (cmd.add_task && IDX_W'(i) == t_idx)
            begin
                rows_next[i] = '0;
                cnt_next[i]  = '0;
            end
            if (cmd.add_dep && IDX_W'(i) == p_idx)
                rows_next[i] = rows_reg[i] | t_bit;
            if (cmd.rem_dep && IDX_W'(i) == p_idx)
                rows_next[i] = rows_reg[i] & ~t_bit;
            if (cmd.add_dep && IDX_W'(i) == t_idx)
                cnt_next[i] = cnt_reg[i] + CNT_W'(1);
            if (cmd.rem_dep && IDX_W'(i) == t_idx && !cnt_zero[i])
                cnt_next[i] = cnt_reg[i] - CNT_W'(1);
            if (cmd.detach)
            begin
                // drop the task and every edge that names it
                if (IDX_W'(i) == t_idx)
                begin
                    rows_next[i] = '0;
                    cnt_next[i]  = '0;
                end
                else
                begin
                    rows_next[i] = rows_reg[i] & ~t_bit;
                    if (cmd.dec_succ && rd_row[i] && !cnt_zero[i])
                        cnt_next[i] = cnt_reg[i] - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_READY;
            present_reg   <= '0;
            unf_reg       <= '0;
            root_reg      <= '0;
            visit_reg     <= '0;
            remain_reg    <= '0;
            pend_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NT; i++)
            begin
                rows_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            phase_reg   <= phase_next;
            present_reg <= present_next;
            unf_reg     <= unf_next;
            root_reg    <= root_next;
            visit_reg   <= visit_next;
            remain_reg  <= remain_next;
            pend_reg    <= pend_next;
            for (int i = 0; i < NT; i++)
            begin
                rows_reg[i] <= rows_next[i];
                cnt_reg[i]  <= cnt_next[i];
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            act_reg <= action;
            t_reg   <= task_id;
            p_reg   <= prereq_id;
        end
        if (cmd.push)
        begin
            kind_reg   <= cmd.kind;
            status_reg <= cmd.status;
            last_reg   <= cmd.last;
            if (cmd.task_root)
                task_reg <= ID_W'(root_reg);
            else if (cmd.task_pend)
                task_reg <= ID_W'(low_idx);
            else
                task_reg <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign result_task = task_reg;
    assign status      = status_reg;
    assign last        = last_reg;

endmodule

// ----- design/dependency_count_task_dispatcher_core.sv -----
// one item at a time: a new item is taken once the last result beat of the
// current one is in the output register, and a beat the sink holds back there
// stalls further beats; start first walks the reach set from the root, then
// prunes the visited set, before its status and dispatch beats.
// async active-low reset empties the task table and returns to the ready phase
// depends on dcd_pkg, dcd_ctrl, dcd_dpath
module dependency_count_task_dispatcher_core (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [2:0]               action,
    input  logic [dcd_pkg::ID_W-1:0] task_id,
    input  logic [dcd_pkg::ID_W-1:0] prereq_id,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [2:0]               kind,
    output logic [dcd_pkg::ID_W-1:0] result_task,
    output logic [2:0]               status,
    output logic                     last
);
    import dcd_pkg::*;

    dcd_cmd_t  cmd;
    dcd_stat_t st;

    dcd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    dcd_dpath u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .action      (action),
        .task_id     (task_id),
        .prereq_id   (prereq_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .result_task (result_task),
        .status      (status),
        .last        (last),
        .cmd         (cmd),
        .st          (st)
    );

endmodule
